/* sv/bcfp_pkg.sv */
// Package for the bracket command frame parser.
// Holds sizes, character codes, command and phase encodings and the
// controller/datapath handshake structs. No dependencies.
`timescale 1ns / 1ps

package bcfp_pkg;

  // Frame buffer size and derived widths
  localparam int CMD_LEN = 8;
  localparam int BUF_AW  = (CMD_LEN > 1) ? $clog2(CMD_LEN) : 1;
  localparam int POS_W   = $clog2(CMD_LEN + 1);

  // Port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int VAL_W       = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_MAX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [VAL_W-1:0] VOLTAGE_MAX_RST    = 16'd65535;
  localparam logic [VAL_W-1:0] HYSTERESIS_MAX_RST = 16'd65535;
  localparam logic [VAL_W-1:0] TIMEOUT_TICKS_RST  = 16'd1000;

  // Item kinds carried on tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Character codes
  localparam logic [7:0] CH_START = 8'h3C;  // '<'
  localparam logic [7:0] CH_END   = 8'h3E;  // '>'
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Run command codes
  typedef enum logic [1:0] {
    RUN_NONE      = 2'd0,
    RUN_CHARGE    = 2'd1,
    RUN_DISCHARGE = 2'd2,
    RUN_RESTART   = 2'd3
  } run_cmd_t;

  // Frame reception phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_COLLECT  = 3'b010,
    PH_WAIT_END = 3'b100
  } phase_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic step;        // apply the accepted item to the frame state
    logic parse_step;  // advance the number parser by one character
    logic load;        // decode the frame and load the output register
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic parse_done;  // number parser finished, or no number to parse
  } dp_sts_t;

endpackage

/* sv/bcfp_datapath.sv */
// Datapath of the bracket command frame parser: frame buffer, timeout timer,
// serial decimal parser, settings and the output register.
// Depends on bcfp_pkg.
`timescale 1ns / 1ps

module bcfp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                item_opcode,
  input  logic [7:0]                          item_byte,
  input  bcfp_pkg::ctrl_cmd_t                 cmd,
  output bcfp_pkg::dp_sts_t                   sts,
  output logic [bcfp_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import bcfp_pkg::*;

  // Configuration
  logic [VAL_W-1:0] vmax_r, hmax_r, tmo_ticks_r;

  // Frame state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       buf_r [CMD_LEN];
  logic [7:0]       buf_nxt [CMD_LEN];
  logic [POS_W-1:0] fill_r, fill_nxt;
  logic [VAL_W-1:0] left_r, left_nxt;
  logic             armed_r, armed_nxt;

  // Per-item flags
  logic acc_r, err_r, tmo_r;
  logic complete_c, error_c, tmo_c;

  // Number parser
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] num_r, num_nxt;
  logic             neg_r, neg_nxt;
  logic             digits_r, digits_nxt;
  logic             pdone_r, pdone_nxt;
  logic [7:0]       pch;
  logic [VAL_W-1:0] pdigit;
  logic             p_blank, p_digit;

  // Settings
  run_cmd_t         run_r, run_nxt;
  logic [VAL_W-1:0] volt_r, volt_nxt;
  logic [VAL_W-1:0] hys_r, hys_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  logic             strobe_c;
  logic [VAL_W-1:0] value_c;

  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmax_r      <= VOLTAGE_MAX_RST;
      hmax_r      <= HYSTERESIS_MAX_RST;
      tmo_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOLTAGE_MAX:    vmax_r      <= cfg_wdata;
        CFG_HYSTERESIS_MAX: hmax_r      <= cfg_wdata;
        CFG_TIMEOUT_TICKS:  tmo_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item step: frame phase, buffer fill and timeout timer
  always_comb begin
    phase_nxt  = phase_r;
    buf_nxt    = buf_r;
    fill_nxt   = fill_r;
    left_nxt   = left_r;
    armed_nxt  = armed_r;
    complete_c = 1'b0;
    error_c    = 1'b0;
    tmo_c      = 1'b0;
    if (cmd.step) begin
      if (item_opcode == OP_TICK) begin
        if (armed_r) begin
          if (left_r <= VAL_W'(1)) begin
            left_nxt  = '0;
            armed_nxt = 1'b0;
            if (phase_r != PH_IDLE) begin
              phase_nxt = PH_IDLE;
              tmo_c     = 1'b1;
            end
          end else begin
            left_nxt = left_r - VAL_W'(1);
          end
        end
      end else begin
        case (phase_r)
          PH_COLLECT: begin
            if (item_byte == CH_END) begin
              complete_c = 1'b1;
              phase_nxt  = PH_IDLE;
            end else if (fill_r < POS_W'(CMD_LEN)) begin
              buf_nxt[fill_r[BUF_AW-1:0]] = item_byte;
              fill_nxt = fill_r + POS_W'(1);
              if (fill_r == POS_W'(CMD_LEN - 1)) phase_nxt = PH_WAIT_END;
            end else begin
              phase_nxt = PH_WAIT_END;
            end
          end
          PH_WAIT_END: begin
            complete_c = (item_byte == CH_END);
            error_c    = (item_byte != CH_END);
            phase_nxt  = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (item_byte == CH_START) begin
              left_nxt  = tmo_ticks_r;
              armed_nxt = 1'b1;
              phase_nxt = PH_COLLECT;
              fill_nxt  = '0;
              for (int i = 0; i < CMD_LEN; i++) buf_nxt[i] = 8'h00;
            end
          end
        endcase
      end
    end
  end

  // Character classes at the parse position
  assign pch     = buf_r[pos_r[BUF_AW-1:0]];
  assign p_blank = (pch == CH_SPACE) || (pch inside {[CH_TAB:CH_CR]});
  assign p_digit = (pch inside {[CH_ZERO:CH_NINE]});
  assign pdigit  = VAL_W'(pch - CH_ZERO);

  // Number parser: one buffer position per step
  always_comb begin
    pos_nxt    = pos_r;
    num_nxt    = num_r;
    neg_nxt    = neg_r;
    digits_nxt = digits_r;
    pdone_nxt  = pdone_r;
    if (cmd.step) begin
      pos_nxt    = POS_W'(1);
      num_nxt    = '0;
      neg_nxt    = 1'b0;
      digits_nxt = 1'b0;
      pdone_nxt  = !(complete_c && (buf_r[0] inside {CH_V, CH_H, CH_I}));
    end else if (cmd.parse_step && !pdone_r) begin
      if (pos_r >= POS_W'(CMD_LEN)) begin
        pdone_nxt = 1'b1;
      end else if (!digits_r) begin
        // leading blanks, then an optional sign or the first digit
        if (p_blank) begin
          pos_nxt = pos_r + POS_W'(1);
        end else if (pch == CH_PLUS || pch == CH_MINUS) begin
          neg_nxt    = (pch == CH_MINUS);
          pos_nxt    = pos_r + POS_W'(1);
          digits_nxt = 1'b1;
        end else if (p_digit) begin
          num_nxt    = pdigit;
          pos_nxt    = pos_r + POS_W'(1);
          digits_nxt = 1'b1;
        end else begin
          pdone_nxt = 1'b1;
        end
      end else begin
        // digit run, value kept modulo 2^16
        if (p_digit) begin
          num_nxt = {num_r[VAL_W-4:0], 3'b000} + {num_r[VAL_W-2:0], 1'b0} + pdigit;
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pdone_nxt = 1'b1;
        end
      end
    end
  end

  // Frame decode on output load
  assign value_c = neg_r ? (VAL_W'(0) - num_r) : num_r;

  always_comb begin
    run_nxt  = run_r;
    volt_nxt = volt_r;
    hys_nxt  = hys_r;
    cur_nxt  = cur_r;
    strobe_c = 1'b0;
    if (cmd.load && acc_r) begin
      case (buf_r[0])
        CH_C: run_nxt = RUN_CHARGE;
        CH_D: run_nxt = RUN_DISCHARGE;
        CH_R: run_nxt = RUN_RESTART;
        CH_V: if (value_c != '0 && value_c < vmax_r) volt_nxt = value_c;
        CH_H: if (value_c != '0 && value_c < hmax_r) hys_nxt = value_c;
        CH_I: begin
          if (value_c != '0) begin
            cur_nxt  = value_c;
            strobe_c = 1'b1;
          end
        end
        default: run_nxt = RUN_NONE;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      fill_r   <= '0;
      left_r   <= '0;
      armed_r  <= 1'b0;
      run_r    <= RUN_NONE;
      volt_r   <= '0;
      hys_r    <= '0;
      cur_r    <= '0;
      pdone_r  <= 1'b1;
      acc_r    <= 1'b0;
      err_r    <= 1'b0;
      tmo_r    <= 1'b0;
      for (int i = 0; i < CMD_LEN; i++) buf_r[i] <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      left_r  <= left_nxt;
      armed_r <= armed_nxt;
      run_r   <= run_nxt;
      volt_r  <= volt_nxt;
      hys_r   <= hys_nxt;
      cur_r   <= cur_nxt;
      pdone_r <= pdone_nxt;
      buf_r   <= buf_nxt;
      if (cmd.step) begin
        acc_r <= complete_c;
        err_r <= error_c;
        tmo_r <= tmo_c;
      end
    end
  end

  // Parser working registers and output payload
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    num_r    <= num_nxt;
    neg_r    <= neg_nxt;
    digits_r <= digits_nxt;
    if (cmd.load) begin
      out_tdata_r <= {2'b00, strobe_c, cur_nxt, hys_nxt, volt_nxt, run_nxt,
                      tmo_r, err_r, acc_r};
    end
  end

  assign sts.parse_done = pdone_r;
  assign out_tdata      = out_tdata_r;

endmodule

/* sv/bcfp_ctrl.sv */
// Controller of the bracket command frame parser: item sequencing state
// machine and output valid flag. Depends on bcfp_pkg.
`timescale 1ns / 1ps

module bcfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  bcfp_pkg::dp_sts_t    sts,
  output bcfp_pkg::ctrl_cmd_t  cmd
);
  import bcfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PARSE  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // Sequencing
  always_comb begin
    state_nxt      = state_r;
    cmd.step       = 1'b0;
    cmd.parse_step = 1'b0;
    cmd.load       = 1'b0;
    in_tready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.step  = 1'b1;
          state_nxt = S_PARSE;
        end
      end
      S_PARSE: begin
        if (sts.parse_done) state_nxt = S_FINISH;
        else cmd.parse_step = 1'b1;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* sv/bracket_command_frame_parser.sv */
// Top level of the bracket command frame parser.
// Instantiates bcfp_ctrl and bcfp_datapath; depends on bcfp_pkg.
`timescale 1ns / 1ps

// Each input item (a received byte or a timer tick) yields exactly one result
// item. Items are handled one at a time: acceptance, a check for a number,
// then decode and load of the output register. Frames starting with V, H or
// I walk the decimal number through the buffer one character per cycle
// before the decode. The output register lets the next item be accepted
// while the previous result still waits on out_tready.
// Configuration writes take effect at once and are meant for idle periods.
module bracket_command_frame_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bcfp_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] frame_accepted, [1] frame_error, [2] timed_out, [4:3] run_command,
  // [20:5] target_voltage, [36:21] hysteresis_value, [52:37] current_limit,
  // [53] current_limit_update, [55:54] zero
  output logic [bcfp_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import bcfp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bcfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bcfp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .item_opcode (in_tuser),
    .item_byte   (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tdata   (out_tdata)
  );

endmodule
